FILE: hdl/rdi_pkg.sv
package rdi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;
  localparam int NW        = 18;
  localparam int RADW      = 31;
  localparam int MINW      = 16;
  localparam int T_W       = 31;
  localparam int DIFF_W    = CW + 1;
  localparam int PN_W      = DIFF_W + NW;
  localparam int PD_W      = CW + NW;
  localparam int NUM_W     = PN_W + 2;
  localparam int DEN_W     = PD_W + 2;
  localparam int AN_W      = NUM_W;
  localparam int AD_W      = DEN_W;
  localparam int REM_W     = AN_W + FRAC_BITS;
  localparam int DIVS_W    = AD_W + T_W;
  localparam int PROD_W    = 64;
  localparam int P_W       = 48;
  localparam int OFF_W     = P_W + 1;
  localparam int SQ_W      = 2 * (CW - 1);
  localparam int D2_W      = SQ_W + 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [NW-1:0]   NORMAL_Y_RST = NW'(65536);
  localparam logic [RADW-1:0] RADIUS_RST   = RADW'(65536);
  localparam logic [MINW-1:0] MIN_DIST_RST = MINW'(66);
  localparam logic [T_W-1:0]  T_MAX        = {T_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_NORMAL_X = 3'd3,
    CFG_NORMAL_Y = 3'd4,
    CFG_NORMAL_Z = 3'd5,
    CFG_RADIUS   = 3'd6,
    CFG_MIN_DIST = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0][CW-1:0] o;
    logic [2:0][CW-1:0] d;
    logic               miss;
    logic               sat;
    logic [T_W-1:0]     q;
    logic [REM_W-1:0]   rem;
    logic [AD_W-1:0]    ad;
  } div_t;

endpackage

FILE: hdl/ray_disk_intersect.sv
// Ray/disk intersection test, fully pipelined.
// Input channel (in_valid/in_ready): one ray per transaction, origin and
// direction in signed Q16.16. Output channel (out_valid/out_ready): one result
// per ray, in order: hit flag, distance t and hit point; all zero on a miss.
// Configuration (cfg_we/cfg_index/cfg_data): disk center, normal, radius and
// minimum distance. The user must write them only while no ray is in flight;
// the block does not enforce this. A ray passes through 4 stages for the dot
// products, 31 stages of the restoring divider (one quotient bit per stage)
// and 6 stages for hit point, disk test and the output register.
// Throughput is one ray per cycle while out_ready is high.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and in_ready drops, so nothing is lost.
// Synchronous reset clears all valid bits and loads the register defaults:
// center at the origin, normal +y, radius 1.0, minimum distance 66 LSB.
module ray_disk_intersect (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            in_origin_x,
  input  logic signed [31:0]            in_origin_y,
  input  logic signed [31:0]            in_origin_z,
  input  logic signed [31:0]            in_dir_x,
  input  logic signed [31:0]            in_dir_y,
  input  logic signed [31:0]            in_dir_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_hit,
  output logic [30:0]                   out_distance,
  output logic signed [31:0]            out_hit_x,
  output logic signed [31:0]            out_hit_y,
  output logic signed [31:0]            out_hit_z,
  input  logic                          cfg_we,
  input  logic [rdi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int CW = rdi_pkg::CW;
  localparam int FB = rdi_pkg::FRAC_BITS;
  localparam int TW = rdi_pkg::T_W;

  // configuration registers
  logic [2:0][CW-1:0]           center_r;
  logic [2:0][rdi_pkg::NW-1:0]  normal_r;
  logic [rdi_pkg::RADW-1:0]     radius_r;
  logic [rdi_pkg::MINW-1:0]     min_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r   <= '0;
      normal_r   <= {{rdi_pkg::NW{1'b0}}, rdi_pkg::NORMAL_Y_RST, {rdi_pkg::NW{1'b0}}};
      radius_r   <= rdi_pkg::RADIUS_RST;
      min_dist_r <= rdi_pkg::MIN_DIST_RST;
    end else if (cfg_we) begin
      case (rdi_pkg::cfg_idx_t'(cfg_index))
        rdi_pkg::CFG_CENTER_X: center_r[0] <= cfg_data;
        rdi_pkg::CFG_CENTER_Y: center_r[1] <= cfg_data;
        rdi_pkg::CFG_CENTER_Z: center_r[2] <= cfg_data;
        rdi_pkg::CFG_NORMAL_X: normal_r[0] <= cfg_data[rdi_pkg::NW-1:0];
        rdi_pkg::CFG_NORMAL_Y: normal_r[1] <= cfg_data[rdi_pkg::NW-1:0];
        rdi_pkg::CFG_NORMAL_Z: normal_r[2] <= cfg_data[rdi_pkg::NW-1:0];
        rdi_pkg::CFG_RADIUS:   radius_r    <= cfg_data[rdi_pkg::RADW-1:0];
        rdi_pkg::CFG_MIN_DIST: min_dist_r  <= cfg_data[rdi_pkg::MINW-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic [2:0][CW-1:0] in_o, in_d;
  assign in_o = {in_origin_z, in_origin_y, in_origin_x};
  assign in_d = {in_dir_z, in_dir_y, in_dir_x};

  // stage 1: center minus origin
  logic                                  v1_r;
  logic [2:0][CW-1:0]                    o1_r, d1_r;
  logic [2:0][rdi_pkg::DIFF_W-1:0]       df1_r;
  // stage 2: products with the normal
  logic                                  v2_r;
  logic [2:0][CW-1:0]                    o2_r, d2_r;
  logic [2:0][rdi_pkg::PN_W-1:0]         pn2_r;
  logic [2:0][rdi_pkg::PD_W-1:0]         pd2_r;
  // stage 3: dot products
  logic                                  v3_r;
  logic [2:0][CW-1:0]                    o3_r, d3_r;
  logic signed [rdi_pkg::NUM_W-1:0]      num3_r;
  logic signed [rdi_pkg::DEN_W-1:0]      den3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      o1_r <= in_o;
      d1_r <= in_d;
      o2_r <= o1_r;
      d2_r <= d1_r;
      o3_r <= o2_r;
      d3_r <= d2_r;
      for (int k = 0; k < 3; k++) begin
        df1_r[k] <= rdi_pkg::DIFF_W'($signed(center_r[k])) -
                    rdi_pkg::DIFF_W'($signed(in_o[k]));
        pn2_r[k] <= rdi_pkg::PN_W'($signed(df1_r[k]) * $signed(normal_r[k]));
        pd2_r[k] <= rdi_pkg::PD_W'($signed(d1_r[k]) * $signed(normal_r[k]));
      end
      num3_r <= rdi_pkg::NUM_W'($signed(pn2_r[0])) + rdi_pkg::NUM_W'($signed(pn2_r[1])) +
                rdi_pkg::NUM_W'($signed(pn2_r[2]));
      den3_r <= rdi_pkg::DEN_W'($signed(pd2_r[0])) + rdi_pkg::DEN_W'($signed(pd2_r[1])) +
                rdi_pkg::DEN_W'($signed(pd2_r[2]));
    end
  end

  // stage 4: signs, magnitudes, saturation check, divider entry
  rdi_pkg::div_t dv_r [0:TW];
  logic          dv_v_r [0:TW];
  rdi_pkg::div_t dv0_nxt;
  logic [rdi_pkg::AN_W-1:0] an;
  logic [rdi_pkg::AD_W-1:0] ad;

  always_comb begin
    an = num3_r[rdi_pkg::NUM_W-1] ? rdi_pkg::AN_W'(-num3_r) : rdi_pkg::AN_W'(num3_r);
    ad = den3_r[rdi_pkg::DEN_W-1] ? rdi_pkg::AD_W'(-den3_r) : rdi_pkg::AD_W'(den3_r);
    dv0_nxt.o    = o3_r;
    dv0_nxt.d    = d3_r;
    dv0_nxt.miss = (den3_r == '0) || (num3_r == '0) ||
                   (num3_r[rdi_pkg::NUM_W-1] != den3_r[rdi_pkg::DEN_W-1]);
    dv0_nxt.sat  = rdi_pkg::DIVS_W'(an) >= (rdi_pkg::DIVS_W'(ad) << (TW - FB));
    dv0_nxt.q    = '0;
    dv0_nxt.rem  = rdi_pkg::REM_W'(an) << FB;
    dv0_nxt.ad   = ad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= v3_r;
      dv_r[0]   <= dv0_nxt;
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar j = 0; j < TW; j++) begin : g_div
    localparam int B = TW - 1 - j;
    logic [rdi_pkg::DIVS_W-1:0] sub;
    logic                       ge;
    rdi_pkg::div_t              st_nxt;

    always_comb begin
      sub    = rdi_pkg::DIVS_W'(dv_r[j].ad) << B;
      ge     = rdi_pkg::DIVS_W'(dv_r[j].rem) >= sub;
      st_nxt = dv_r[j];
      if (ge) begin
        st_nxt.rem  = rdi_pkg::REM_W'(rdi_pkg::DIVS_W'(dv_r[j].rem) - sub);
        st_nxt.q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j+1] <= dv_v_r[j];
        dv_r[j+1]   <= st_nxt;
      end
    end
  end

  // stage 5: t and minimum distance test
  logic               v5_r, miss5_r;
  logic [TW-1:0]      t5_r;
  logic [2:0][CW-1:0] o5_r, d5_r;
  logic [TW-1:0]      t_nxt;
  assign t_nxt = dv_r[TW].sat ? rdi_pkg::T_MAX : dv_r[TW].q;

  // stage 6: t times direction
  logic                           v6_r, miss6_r;
  logic [TW-1:0]                  t6_r;
  logic [2:0][CW-1:0]             o6_r;
  logic [2:0][rdi_pkg::PROD_W-1:0] prod6_r;
  // stage 7: hit point
  logic                           v7_r, miss7_r;
  logic [TW-1:0]                  t7_r;
  logic [2:0][rdi_pkg::P_W-1:0]   p7_r;
  // stage 8: offset from center
  logic                           v8_r, miss8_r;
  logic [TW-1:0]                  t8_r;
  logic [2:0][rdi_pkg::P_W-1:0]   p8_r;
  logic [2:0][CW-2:0]             offm8_r;
  // stage 9: squares
  logic                           v9_r, miss9_r;
  logic [TW-1:0]                  t9_r;
  logic [2:0][rdi_pkg::P_W-1:0]   p9_r;
  logic [2:0][rdi_pkg::SQ_W-1:0]  sq9_r;
  logic [rdi_pkg::SQ_W-1:0]       rad2_9_r;

  logic [2:0][rdi_pkg::PROD_W-1:0] prod_sh;
  logic [2:0][rdi_pkg::P_W-1:0]    p_nxt;
  logic [2:0][rdi_pkg::OFF_W-1:0]  off, offm;
  logic [2:0]                      big;
  logic [rdi_pkg::D2_W-1:0]        dist2;
  logic                            hit_nxt;
  logic [2:0][CW-1:0]              ps_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_sh[k] = rdi_pkg::PROD_W'($signed(prod6_r[k]) >>> FB);
      p_nxt[k]   = prod_sh[k][rdi_pkg::P_W-1:0] + rdi_pkg::P_W'($signed(o6_r[k]));
      off[k]     = rdi_pkg::OFF_W'($signed(p7_r[k])) - rdi_pkg::OFF_W'($signed(center_r[k]));
      offm[k]    = off[k][rdi_pkg::OFF_W-1] ? -off[k] : off[k];
      big[k]     = |offm[k][rdi_pkg::OFF_W-1:CW-1];
      if (p9_r[k][rdi_pkg::P_W-1:CW-1] == '0 || &p9_r[k][rdi_pkg::P_W-1:CW-1])
        ps_nxt[k] = p9_r[k][CW-1:0];
      else
        ps_nxt[k] = p9_r[k][rdi_pkg::P_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    dist2   = rdi_pkg::D2_W'(sq9_r[0]) + rdi_pkg::D2_W'(sq9_r[1]) + rdi_pkg::D2_W'(sq9_r[2]);
    hit_nxt = !miss9_r && (dist2 < rdi_pkg::D2_W'(rad2_9_r));
  end

  logic               out_valid_r, out_hit_r;
  logic [TW-1:0]      out_dist_r;
  logic [2:0][CW-1:0] out_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v5_r        <= dv_v_r[TW];
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      v9_r        <= v8_r;
      out_valid_r <= v9_r;

      miss5_r <= dv_r[TW].miss || (t_nxt <= TW'(min_dist_r));
      t5_r    <= t_nxt;
      o5_r    <= dv_r[TW].o;
      d5_r    <= dv_r[TW].d;

      miss6_r <= miss5_r;
      t6_r    <= t5_r;
      o6_r    <= o5_r;
      for (int k = 0; k < 3; k++)
        prod6_r[k] <= rdi_pkg::PROD_W'($signed({1'b0, t5_r}) * $signed(d5_r[k]));

      miss7_r <= miss6_r;
      t7_r    <= t6_r;
      p7_r    <= p_nxt;

      miss8_r <= miss7_r || (|big);
      t8_r    <= t7_r;
      p8_r    <= p7_r;
      for (int k = 0; k < 3; k++)
        offm8_r[k] <= offm[k][CW-2:0];

      miss9_r  <= miss8_r;
      t9_r     <= t8_r;
      p9_r     <= p8_r;
      rad2_9_r <= rdi_pkg::SQ_W'(radius_r * radius_r);
      for (int k = 0; k < 3; k++)
        sq9_r[k] <= rdi_pkg::SQ_W'(offm8_r[k] * offm8_r[k]);

      out_hit_r  <= hit_nxt;
      out_dist_r <= hit_nxt ? t9_r : '0;
      out_p_r    <= hit_nxt ? ps_nxt : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_is_hit   = out_hit_r;
  assign out_distance = out_dist_r;
  assign out_hit_x    = out_p_r[0];
  assign out_hit_y    = out_p_r[1];
  assign out_hit_z    = out_p_r[2];

endmodule

FILE: hdl/rdi_checker.sv
module rdi_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic signed [31:0]            in_origin_x,
  input logic signed [31:0]            in_origin_y,
  input logic signed [31:0]            in_origin_z,
  input logic signed [31:0]            in_dir_x,
  input logic signed [31:0]            in_dir_y,
  input logic signed [31:0]            in_dir_z,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_is_hit,
  input logic [30:0]                   out_distance,
  input logic signed [31:0]            out_hit_x,
  input logic signed [31:0]            out_hit_y,
  input logic signed [31:0]            out_hit_z,
  input logic                          cfg_we,
  input logic [rdi_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]                   cfg_data
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) && $stable(out_is_hit))
    else $error("stalled result changed");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_hit |-> out_distance == '0 && out_hit_x == '0 &&
    out_hit_y == '0 && out_hit_z == '0)
    else $error("miss result not zero");

  a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_hit |-> out_distance != '0)
    else $error("hit with zero distance");

endmodule

bind ray_disk_intersect rdi_checker u_rdi_checker (.*);
